>>> design/srbl_pkg.sv
// ----------------------------------------------------------------------------
// srbl_pkg
// Shared types, constants and sequence-compare helpers for the SACK receiver
// block list.
// ----------------------------------------------------------------------------
package srbl_pkg;

   localparam int MAX_BLOCKS = 4;
   localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
   localparam int SEQ_W      = 32;
   localparam int RSP_CNT_W  = 3;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_PURGE = 1'b1;

   typedef struct packed {
      logic             op;
      logic [SEQ_W-1:0] cum_ack;
      logic [SEQ_W-1:0] range_start;
      logic [SEQ_W-1:0] range_end;
   } req_type;

   typedef struct packed {
      logic [SEQ_W-1:0]     block_start;
      logic [SEQ_W-1:0]     block_end;
      logic [RSP_CNT_W-1:0] block_count;
      logic                 block_valid;
      logic                 last_block;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scan_step;
      logic commit;
      logic emit;
      logic clr_idx;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic skip;
      logic scan_done;
      logic emit_last;
   } status_type;

   // Modular compare: a is before b when the difference is negative.
   function automatic logic seq_lt(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] diff;
      diff = a - b;
      return diff[SEQ_W-1];
   endfunction

   function automatic logic seq_leq(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
      return (a == b) || seq_lt(a, b);
   endfunction

endpackage

>>> design/srbl_datapath.sv
// ----------------------------------------------------------------------------
// srbl_datapath
// Block storage, the per-entry merge and trim logic, the kept-block buffer
// and the registered result port.
// ----------------------------------------------------------------------------
module srbl_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  srbl_pkg::req_type    req_data,
   input  srbl_pkg::cmd_type    cmd,
   output srbl_pkg::status_type status,
   output srbl_pkg::rsp_type    rsp_data,
   output logic                 rsp_strobe
);

   logic                          op_ff, op_in;
   logic [srbl_pkg::SEQ_W-1:0]    ack_ff, ack_in;
   logic [srbl_pkg::SEQ_W-1:0]    s_ff, s_in;
   logic [srbl_pkg::SEQ_W-1:0]    e_ff, e_in;
   logic                          skip_ff, skip_in;
   logic [srbl_pkg::CNT_W-1:0]    idx_ff, idx_in;
   logic [srbl_pkg::CNT_W-1:0]    kcnt_ff, kcnt_in;
   logic [srbl_pkg::CNT_W-1:0]    held_count_ff, held_count_in;
   logic [srbl_pkg::SEQ_W-1:0]    held_start_ff [srbl_pkg::MAX_BLOCKS];
   logic [srbl_pkg::SEQ_W-1:0]    held_start_in [srbl_pkg::MAX_BLOCKS];
   logic [srbl_pkg::SEQ_W-1:0]    held_end_ff   [srbl_pkg::MAX_BLOCKS];
   logic [srbl_pkg::SEQ_W-1:0]    held_end_in   [srbl_pkg::MAX_BLOCKS];
   logic [srbl_pkg::SEQ_W-1:0]    kept_start_ff [srbl_pkg::MAX_BLOCKS];
   logic [srbl_pkg::SEQ_W-1:0]    kept_start_in [srbl_pkg::MAX_BLOCKS];
   logic [srbl_pkg::SEQ_W-1:0]    kept_end_ff   [srbl_pkg::MAX_BLOCKS];
   logic [srbl_pkg::SEQ_W-1:0]    kept_end_in   [srbl_pkg::MAX_BLOCKS];
   srbl_pkg::rsp_type             rsp_ff, rsp_in;
   logic                          rsp_strobe_ff, rsp_strobe_in;

   logic [srbl_pkg::IDX_W-1:0]    rd_idx;
   logic [srbl_pkg::IDX_W-1:0]    kept_idx;
   logic [srbl_pkg::SEQ_W-1:0]    bs, be;
   logic [srbl_pkg::SEQ_W-1:0]    req_s_clamp;
   logic                          req_skip;
   logic                          drop, merge;
   logic                          emit_last;
   logic [srbl_pkg::CNT_W-1:0]    idx_next;

   assign rd_idx   = idx_ff[srbl_pkg::IDX_W-1:0];
   assign kept_idx = kcnt_ff[srbl_pkg::IDX_W-1:0];
   assign bs       = held_start_ff[rd_idx];
   assign be       = held_end_ff[rd_idx];
   assign idx_next = idx_ff + srbl_pkg::CNT_W'(1);

   // Clamp the range start to the ack; an empty or fully acked add range is a no-op.
   assign req_s_clamp = srbl_pkg::seq_lt(req_data.range_start, req_data.cum_ack) ?
                        req_data.cum_ack : req_data.range_start;
   assign req_skip    = (req_data.op == srbl_pkg::OP_ADD) &&
                        (srbl_pkg::seq_leq(req_data.range_end, req_data.cum_ack) ||
                         !srbl_pkg::seq_lt(req_s_clamp, req_data.range_end));

   assign drop  = srbl_pkg::seq_leq(be, ack_ff);
   assign merge = srbl_pkg::seq_leq(s_ff, be) && srbl_pkg::seq_leq(bs, e_ff);

   assign emit_last = (held_count_ff == '0) || (idx_next == held_count_ff);

   assign status.skip      = skip_ff;
   assign status.scan_done = (idx_ff == held_count_ff);
   assign status.emit_last = emit_last;

   always_comb begin
      op_in         = op_ff;
      ack_in        = ack_ff;
      s_in          = s_ff;
      e_in          = e_ff;
      skip_in       = skip_ff;
      idx_in        = idx_ff;
      kcnt_in       = kcnt_ff;
      held_count_in = held_count_ff;
      held_start_in = held_start_ff;
      held_end_in   = held_end_ff;
      kept_start_in = kept_start_ff;
      kept_end_in   = kept_end_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;

      if (cmd.load) begin
         op_in   = req_data.op;
         ack_in  = req_data.cum_ack;
         s_in    = req_s_clamp;
         e_in    = req_data.range_end;
         skip_in = req_skip;
         idx_in  = '0;
         kcnt_in = '0;
      end

      if (cmd.scan_step) begin
         idx_in = idx_next;
         if (!drop) begin
            if (op_ff == srbl_pkg::OP_ADD && merge) begin
               s_in = srbl_pkg::seq_lt(bs, s_ff) ? bs : s_ff;
               e_in = srbl_pkg::seq_lt(e_ff, be) ? be : e_ff;
            end else begin
               // A purge trims the left edge; an add keeps the block as it is.
               kept_start_in[kept_idx] = (op_ff == srbl_pkg::OP_PURGE &&
                                          srbl_pkg::seq_lt(bs, ack_ff)) ? ack_ff : bs;
               kept_end_in[kept_idx]   = be;
               kcnt_in                 = kcnt_ff + srbl_pkg::CNT_W'(1);
            end
         end
      end

      if (cmd.commit) begin
         if (op_ff == srbl_pkg::OP_ADD) begin
            held_start_in[0] = s_ff;
            held_end_in[0]   = e_ff;
            for (int k = 0; k < srbl_pkg::MAX_BLOCKS - 1; k++) begin
               held_start_in[k+1] = kept_start_ff[k];
               held_end_in[k+1]   = kept_end_ff[k];
            end
            held_count_in = (kcnt_ff >= srbl_pkg::CNT_W'(srbl_pkg::MAX_BLOCKS - 1)) ?
                            srbl_pkg::CNT_W'(srbl_pkg::MAX_BLOCKS) :
                            kcnt_ff + srbl_pkg::CNT_W'(1);
         end else begin
            held_start_in = kept_start_ff;
            held_end_in   = kept_end_ff;
            held_count_in = kcnt_ff;
         end
      end

      if (cmd.clr_idx) begin
         idx_in = '0;
      end

      if (cmd.emit) begin
         idx_in        = idx_next;
         rsp_strobe_in = 1'b1;
         if (held_count_ff == '0) begin
            rsp_in.block_start = '0;
            rsp_in.block_end   = '0;
            rsp_in.block_count = '0;
            rsp_in.block_valid = 1'b0;
            rsp_in.last_block  = 1'b1;
         end else begin
            rsp_in.block_start = bs;
            rsp_in.block_end   = be;
            rsp_in.block_count = held_count_ff[srbl_pkg::RSP_CNT_W-1:0];
            rsp_in.block_valid = 1'b1;
            rsp_in.last_block  = emit_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         kcnt_ff       <= '0;
         held_count_ff <= '0;
         skip_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         kcnt_ff       <= kcnt_in;
         held_count_ff <= held_count_in;
         skip_ff       <= skip_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      ack_ff        <= ack_in;
      s_ff          <= s_in;
      e_ff          <= e_in;
      held_start_ff <= held_start_in;
      held_end_ff   <= held_end_in;
      kept_start_ff <= kept_start_in;
      kept_end_ff   <= kept_end_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_data   = rsp_ff;
   assign rsp_strobe = rsp_strobe_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      held_count_ff <= srbl_pkg::CNT_W'(srbl_pkg::MAX_BLOCKS))
      else $error("held block count exceeds capacity");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.block_valid) |->
         (rsp_data.last_block && rsp_data.block_count == '0))
      else $error("empty-list result is not a lone final item");

   a_add_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && op_ff == srbl_pkg::OP_ADD) |=> (held_count_ff != '0))
      else $error("an add left the list empty");

endmodule

>>> design/srbl_ctrl.sv
// ----------------------------------------------------------------------------
// srbl_ctrl
// Sequencer for one item: scan the stored blocks, commit the new list (an add
// that changes nothing skips both) and report it one block per cycle.
// ----------------------------------------------------------------------------
module srbl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  srbl_pkg::status_type status,
   output srbl_pkg::cmd_type    cmd,
   output logic                 busy
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // A no-op add leaves the list alone and goes straight to reporting.
            if (status.skip) begin
               cmd.clr_idx = 1'b1;
               state_in    = ST_EMIT;
            end else if (status.scan_done) begin
               state_in = ST_COMMIT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_COMMIT: begin
            cmd.commit  = 1'b1;
            cmd.clr_idx = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && state_ff == ST_SCAN))
      else $error("accepted item did not start a scan");

   a_commit_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT) |=> (state_ff == ST_EMIT))
      else $error("commit not followed by reporting");

endmodule

>>> design/sack_receiver_block_list_top.sv
// ----------------------------------------------------------------------------
// sack_receiver_block_list_top
// SACK receiver block list: keeps up to MAX_BLOCKS out-of-order ranges, most
// recent first, and reports the whole list after every item.
// ----------------------------------------------------------------------------
// Usage:
//   An item (op, cum_ack, range_start, range_end on req_data) is accepted at
//   a clock edge where start is high and busy is low. An add merges the
//   clamped range into a new head; a purge drops or trims acked blocks.
//   Results leave on rsp_data, one block per cycle head first, each marked
//   by a one-cycle rsp_strobe; the last carries last_block. An empty list
//   gives one result with block_valid low. The receiver cannot stall.
// Sequence:
//   The scan reads the stored blocks one entry at a time; once it is done
//   the new list is committed and then reported. An add that changes
//   nothing reads no stored entry and skips the commit. The result port is
//   registered; the next item may be accepted once busy drops, while the
//   last result is still on the port.
// Reset:
//   Synchronous reset empties the list and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module sack_receiver_block_list_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  srbl_pkg::req_type req_data,
   output srbl_pkg::rsp_type rsp_data,
   output logic              rsp_strobe
);

   srbl_pkg::cmd_type    cmd;
   srbl_pkg::status_type status;

   srbl_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   srbl_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_data   (rsp_data),
      .rsp_strobe (rsp_strobe)
   );

endmodule
